// ===== design/scr_pkg.sv =====
// ----------------------------------------------------------------------------
// scr_pkg
// Shared widths, depths and memory word layouts of the SIEVE replacement block.
// ----------------------------------------------------------------------------
package scr_pkg;

    // Field and storage widths
    localparam int ADDR_W     = 16;
    localparam int SLOT_W     = 12;
    localparam int CNT_W      = 13;
    localparam int TIME_W     = 32;
    localparam int AMAP_DEPTH = 65536;
    localparam int SLOT_DEPTH = 4096;
    localparam logic [CNT_W-1:0] MAX_CAP = CNT_W'(SLOT_DEPTH);
    localparam int CFG_W      = 16;

    // One cache slot: address, visited mark, queue links and time stamps.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              visited;
        logic [SLOT_W-1:0] newer;
        logic [SLOT_W-1:0] older;
        logic [TIME_W-1:0] enter;
        logic [TIME_W-1:0] refs;
    } t_slot;

    // One address map entry: present flag and the slot holding the address.
    typedef struct packed {
        logic              present;
        logic [SLOT_W-1:0] slot;
    } t_amap;

    localparam int SLOT_BITS = $bits(t_slot);
    localparam int AMAP_BITS = $bits(t_amap);

endpackage

// ===== design/scr_ram.sv =====
// ----------------------------------------------------------------------------
// scr_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module scr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; a read returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sieve_cache_replacement_top.sv =====
// ----------------------------------------------------------------------------
// sieve_cache_replacement_top
// SIEVE cache replacement simulator built around an address map RAM and a
// slot RAM, driven by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// Usage: each slave transaction on s_t* carries one block address. The block
// answers with exactly one master transaction: m_tuser holds the hit and
// eviction flags, m_tdata the evicted address and its two ages.
// Capacity is written through the i_cfg_* channel; the user must write it only
// while the block is idle, as the block itself does not enforce this. The
// single read port of the slot RAM sets the length of each access: every queue
// link update is a read followed by a write. An evicting miss also scans each
// visited entry the hand clears, up to the number of stored entries.
// One address is processed at a time; the next is taken once the result has
// moved into the output register, so a stalled receiver holds the block only
// when a second result is ready.
// After reset the address map is cleared, one entry per cycle, over all 65536
// entries; no address is taken during that pass, configuration still is.
// ----------------------------------------------------------------------------
module sieve_cache_replacement_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] block_addr
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [15:0] evicted_addr, [47:16] evicted_ref_age,
                                   // [79:48] evicted_enter_age
    output logic [1:0]  m_tuser,   // [0] hit, [1] evicted_valid
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data // [12:0] capacity
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_HIT_W, S_SCAN, S_UN1, S_UN2,
        S_INS, S_INS_W, S_INS_SLOT, S_DONE
    } t_state;

    t_state                        r_state;
    logic [scr_pkg::ADDR_W-1:0]    r_clr;
    logic [scr_pkg::ADDR_W-1:0]    r_addr;
    logic [scr_pkg::TIME_W-1:0]    r_cnt;
    logic [scr_pkg::CNT_W-1:0]     r_cap;
    logic [scr_pkg::CNT_W-1:0]     r_occ;
    logic [scr_pkg::SLOT_W-1:0]    r_head;
    logic [scr_pkg::SLOT_W-1:0]    r_tail;
    logic [scr_pkg::SLOT_W-1:0]    r_hand;
    logic                          r_hand_v;
    logic [scr_pkg::SLOT_W-1:0]    r_it;
    scr_pkg::t_slot                r_vict;
    logic                          r_was_tail;
    logic                          r_hit;
    logic                          r_ev;
    logic [scr_pkg::TIME_W-1:0]    r_rage;
    logic [scr_pkg::TIME_W-1:0]    r_eage;
    logic                          r_ovalid;
    logic [1:0]                    r_ouser;
    logic [79:0]                   r_odata;
    logic                          r_fwd;
    scr_pkg::t_slot                r_fwd_data;

    // Memory ports
    logic                          a_we, a_re;
    logic [scr_pkg::ADDR_W-1:0]    a_waddr, a_raddr;
    scr_pkg::t_amap                a_wdata, a_q;
    logic                          s_we, s_re;
    logic [scr_pkg::SLOT_W-1:0]    s_waddr, s_raddr;
    scr_pkg::t_slot                s_wdata, s_qraw, d;

    logic [scr_pkg::CNT_W-1:0]     cap_eff;
    logic [scr_pkg::SLOT_W-1:0]    scan_next;
    logic                          accept;
    logic                          out_free;

    scr_ram #(.WIDTH(scr_pkg::AMAP_BITS), .DEPTH(scr_pkg::AMAP_DEPTH)) u_amap (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_re(a_re), .i_raddr(a_raddr), .o_rdata(a_q)
    );

    scr_ram #(.WIDTH(scr_pkg::SLOT_BITS), .DEPTH(scr_pkg::SLOT_DEPTH)) u_slot (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_re(s_re), .i_raddr(s_raddr), .o_rdata(s_qraw)
    );

    // Slot read data, with forwarding of a write to the address read alongside.
    assign d         = r_fwd ? r_fwd_data : s_qraw;
    assign cap_eff   = (r_cap > scr_pkg::MAX_CAP) ? scr_pkg::MAX_CAP : r_cap;
    assign scan_next = (r_it == r_head) ? r_tail : d.newer;
    assign s_tready  = (r_state == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !r_ovalid || m_tready;
    assign o_cfg_ready = 1'b1;
    assign m_tvalid  = r_ovalid;
    assign m_tdata   = r_odata;
    assign m_tuser   = r_ouser;

    // Memory port control for each step of the sequence.
    always_comb begin
        a_we    = 1'b0;
        a_waddr = r_addr;
        a_wdata = '0;
        a_re    = 1'b0;
        a_raddr = s_tdata;
        s_we    = 1'b0;
        s_waddr = r_it;
        s_wdata = d;
        s_re    = 1'b0;
        s_raddr = r_it;
        case (r_state)
            S_CLEAR: begin
                a_we    = 1'b1;
                a_waddr = r_clr;
            end
            S_IDLE: begin
                a_re = accept;
            end
            S_LOOK: begin
                if (a_q.present) begin
                    s_re    = 1'b1;
                    s_raddr = a_q.slot;
                end else if (r_occ >= cap_eff && r_occ != '0) begin
                    s_re    = 1'b1;
                    s_raddr = r_hand_v ? r_hand : r_tail;
                end
            end
            S_HIT_W: begin
                s_we            = 1'b1;
                s_wdata.visited = 1'b1;
                s_wdata.refs    = r_cnt;
            end
            S_SCAN: begin
                if (d.visited) begin
                    s_we            = 1'b1;
                    s_wdata.visited = 1'b0;
                    s_re            = 1'b1;
                    s_raddr         = scan_next;
                end else begin
                    a_we    = 1'b1;
                    a_waddr = d.addr;
                    if (r_it != r_head) begin
                        s_re    = 1'b1;
                        s_raddr = d.newer;
                    end else if (r_it != r_tail) begin
                        s_re    = 1'b1;
                        s_raddr = d.older;
                    end
                end
            end
            S_UN1: begin
                s_we          = 1'b1;
                s_waddr       = r_vict.newer;
                s_wdata.older = r_vict.older;
                if (!r_was_tail) begin
                    s_re    = 1'b1;
                    s_raddr = r_vict.older;
                end
            end
            S_UN2: begin
                s_we          = 1'b1;
                s_waddr       = r_vict.older;
                s_wdata.newer = r_vict.newer;
            end
            S_INS: begin
                s_re    = (r_occ != '0);
                s_raddr = r_head;
            end
            S_INS_W: begin
                s_we          = 1'b1;
                s_waddr       = r_head;
                s_wdata.newer = r_it;
            end
            S_INS_SLOT: begin
                s_we            = 1'b1;
                s_wdata.addr    = r_addr;
                s_wdata.visited = 1'b0;
                s_wdata.newer   = r_it;
                s_wdata.older   = (r_occ == '0) ? r_it : r_head;
                s_wdata.enter   = r_cnt;
                s_wdata.refs    = r_cnt;
                a_we            = 1'b1;
                a_wdata.present = 1'b1;
                a_wdata.slot    = r_it;
            end
            default: begin
            end
        endcase
    end

    // Sequencer, queue pointers and output register.
    always_ff @(posedge i_clk) begin
        r_fwd      <= s_we && s_re && (s_waddr == s_raddr);
        r_fwd_data <= s_wdata;
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_cnt    <= '0;
            r_cap    <= scr_pkg::MAX_CAP;
            r_occ    <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_hand   <= '0;
            r_hand_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data[scr_pkg::CNT_W-1:0];
            end
            // The done step loads a new result; otherwise a taken one leaves.
            if (r_ovalid && m_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_addr  <= s_tdata;
                        r_cnt   <= r_cnt + 1'b1;
                        r_hit   <= 1'b0;
                        r_ev    <= 1'b0;
                        r_vict  <= '0;
                        r_rage  <= '0;
                        r_eage  <= '0;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (a_q.present) begin
                        r_hit   <= 1'b1;
                        r_it    <= a_q.slot;
                        r_state <= S_HIT_W;
                    end else if (r_occ < cap_eff) begin
                        r_it    <= r_occ[scr_pkg::SLOT_W-1:0];
                        r_state <= S_INS;
                    end else if (r_occ != '0) begin
                        r_it    <= r_hand_v ? r_hand : r_tail;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_HIT_W: begin
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    if (d.visited) begin
                        r_it <= scan_next;
                    end else begin
                        // Victim found: report it, move the hand, unlink it.
                        r_vict     <= d;
                        r_ev       <= 1'b1;
                        r_rage     <= r_cnt - d.refs;
                        r_eage     <= r_cnt - d.enter;
                        r_was_tail <= (r_it == r_tail);
                        r_occ      <= r_occ - 1'b1;
                        r_hand_v   <= (r_it != r_head);
                        if (r_it != r_head) begin
                            r_hand <= d.newer;
                        end
                        if (r_it == r_head) begin
                            r_head <= d.older;
                        end
                        if (r_it == r_tail) begin
                            r_tail <= d.newer;
                        end
                        if (r_it != r_head) begin
                            r_state <= S_UN1;
                        end else if (r_it != r_tail) begin
                            r_state <= S_UN2;
                        end else begin
                            r_state <= S_INS;
                        end
                    end
                end
                S_UN1: begin
                    r_state <= r_was_tail ? S_INS : S_UN2;
                end
                S_UN2: begin
                    r_state <= S_INS;
                end
                S_INS: begin
                    r_state <= (r_occ != '0) ? S_INS_W : S_INS_SLOT;
                end
                S_INS_W: begin
                    r_state <= S_INS_SLOT;
                end
                S_INS_SLOT: begin
                    r_head <= r_it;
                    if (r_occ == '0) begin
                        r_tail <= r_it;
                    end
                    r_occ   <= r_occ + 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ouser  <= {r_ev, r_hit};
                        r_odata  <= {r_eage, r_rage, r_vict.addr};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== bench/sieve_cache_replacement_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sieve_cache_replacement_top_tb
// Self-checking bench for the SIEVE replacement block. Block addresses are
// streamed in bursts while the result side stalls on its own pattern. A SIEVE
// predictor inside the bench holds the queue, hand, visited marks and time
// stamps. It computes each result when the address transaction is accepted,
// and the monitor compares every result transaction field by field.
// ----------------------------------------------------------------------------
module sieve_cache_replacement_top_tb;

    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic                       hit;
        logic                       evicted;
        logic [scr_pkg::ADDR_W-1:0] ev_addr;
        logic [scr_pkg::TIME_W-1:0] ref_age;
        logic [scr_pkg::TIME_W-1:0] ins_age;
    } t_access_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] block_addr
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // [15:0] evicted_addr, [47:16] evicted_ref_age,
                            // [79:48] evicted_enter_age
    logic [1:0]  m_tuser;   // [0] hit, [1] evicted_valid
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data; // [12:0] capacity

    sieve_cache_replacement_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state of the cache.
    bit                         present_bit [scr_pkg::AMAP_DEPTH];
    bit                         visited_bit [scr_pkg::AMAP_DEPTH];
    logic [scr_pkg::TIME_W-1:0] ins_stamp   [scr_pkg::AMAP_DEPTH];
    logic [scr_pkg::TIME_W-1:0] touch_stamp [scr_pkg::AMAP_DEPTH];
    logic [scr_pkg::ADDR_W-1:0] slot_tag    [scr_pkg::SLOT_DEPTH];
    logic [scr_pkg::SLOT_W-1:0] slot_nxt    [scr_pkg::SLOT_DEPTH];
    logic [scr_pkg::SLOT_W-1:0] slot_prv    [scr_pkg::SLOT_DEPTH];
    logic [scr_pkg::SLOT_W-1:0] head_ptr, tail_ptr, hand_ptr;
    bit                         hand_on;
    int                         occupied;
    logic [scr_pkg::TIME_W-1:0] now_count;
    logic [scr_pkg::CNT_W-1:0]  cur_capacity;

    t_access_result pending_results[$];
    int  error_count;
    int  items_sent, hits_seen, evictions_seen;
    int  idle_cycles;
    int  burst_left;
    bit  all_sent;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Place an address at the head of the queue in slot s.
    function void place_head(logic [scr_pkg::SLOT_W-1:0] s, logic [scr_pkg::ADDR_W-1:0] a);
        slot_tag[s] = a;
        slot_nxt[s] = s;
        if (occupied == 0) begin
            slot_prv[s] = s;
            tail_ptr = s;
        end else begin
            slot_prv[s] = head_ptr;
            slot_nxt[head_ptr] = s;
        end
        head_ptr = s;
        occupied++;
        present_bit[a] = 1'b1;
        visited_bit[a] = 1'b0;
        ins_stamp[a] = now_count;
        touch_stamp[a] = now_count;
    endfunction

    // SIEVE access: returns the expected result and updates the cache state.
    function t_access_result sieve_access(logic [scr_pkg::ADDR_W-1:0] a);
        t_access_result r;
        int cap;
        int guard;
        logic [scr_pkg::SLOT_W-1:0] it;
        logic [scr_pkg::ADDR_W-1:0] va;
        r = '0;
        cap = (cur_capacity > scr_pkg::MAX_CAP) ? scr_pkg::SLOT_DEPTH : int'(cur_capacity);
        now_count = now_count + 1'b1;
        if (present_bit[a]) begin
            r.hit = 1'b1;
            visited_bit[a] = 1'b1;
            touch_stamp[a] = now_count;
        end else if (occupied < cap) begin
            place_head(scr_pkg::SLOT_W'(occupied), a);
        end else if (occupied > 0) begin
            // Sweep the hand toward the head, clearing visited marks.
            it = hand_on ? hand_ptr : tail_ptr;
            guard = 0;
            forever begin
                va = slot_tag[it];
                if (!visited_bit[va] || guard > 2 * scr_pkg::SLOT_DEPTH) break;
                visited_bit[va] = 1'b0;
                it = (it == head_ptr) ? tail_ptr : slot_nxt[it];
                guard++;
            end
            r.ref_age = now_count - touch_stamp[va];
            r.ins_age = now_count - ins_stamp[va];
            if (it == head_ptr) begin
                hand_on = 1'b0;
            end else begin
                hand_ptr = slot_nxt[it];
                hand_on = 1'b1;
            end
            // Unlink the victim slot.
            if (it == head_ptr) head_ptr = slot_prv[it];
            else slot_prv[slot_nxt[it]] = slot_prv[it];
            if (it == tail_ptr) tail_ptr = slot_nxt[it];
            else slot_nxt[slot_prv[it]] = slot_nxt[it];
            occupied--;
            present_bit[va] = 1'b0;
            visited_bit[va] = 1'b0;
            r.evicted = 1'b1;
            r.ev_addr = va;
            place_head(it, a);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    // Monitor: predict on each accepted address, check each accepted result.
    always @(posedge i_clk) begin
        t_access_result want;
        if (i_rst_n && s_tvalid && s_tready) begin
            pending_results.push_back(sieve_access(s_tdata));
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 64'({m_tuser, m_tdata[15:0]}), 64'd0);
            end else begin
                want = pending_results.pop_front();
                hits_seen += int'(want.hit);
                evictions_seen += int'(want.evicted);
                if (m_tuser[0] !== want.hit)
                    report_mismatch("hit", 64'(m_tuser[0]), 64'(want.hit));
                if (m_tuser[1] !== want.evicted)
                    report_mismatch("evicted_valid", 64'(m_tuser[1]), 64'(want.evicted));
                if (m_tdata[15:0] !== want.ev_addr)
                    report_mismatch("evicted_addr", 64'(m_tdata[15:0]), 64'(want.ev_addr));
                if (m_tdata[47:16] !== want.ref_age)
                    report_mismatch("evicted_ref_age", 64'(m_tdata[47:16]),
                                    64'(want.ref_age));
                if (m_tdata[79:48] !== want.ins_age)
                    report_mismatch("evicted_enter_age", 64'(m_tdata[79:48]),
                                    64'(want.ins_age));
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pending_results.size());
            $display("sieve_cache_replacement_top_tb: errors");
            $finish;
        end
    end

    // Result side stall pattern: free running, random, or long periodic stalls.
    always @(negedge i_clk) begin
        int phase;
        phase = int'(($time / 10) % 3000);
        if (!i_rst_n || all_sent) m_tready <= 1'b1;
        else if (phase < 800) m_tready <= 1'b1;
        else if (phase < 2000) m_tready <= ($urandom_range(0, 99) < 65);
        else m_tready <= ((phase % 40) < 28);
    end

    // Send one address; the sender runs in bursts separated by random gaps.
    // The ready level seen at a falling edge holds until the next rising edge.
    task automatic send_addr(logic [scr_pkg::ADDR_W-1:0] a);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= a;
        while (!s_tready) @(negedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Hold the sender until every result is back, then let the block settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [scr_pkg::CNT_W-1:0] cap);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= {3'($urandom), cap};
        while (!o_cfg_ready) @(negedge i_clk);
        @(negedge i_clk);
        cur_capacity = cap;
        i_cfg_valid <= 1'b0;
    endtask

    // Reset capacity: inserts into a large empty cache, then some hits.
    task automatic test_reset_capacity();
        send_addr(16'h0000);
        send_addr(16'hFFFF);
        send_addr(16'h0000);
        repeat (150) send_addr(16'($urandom));
        send_addr(16'hFFFF);
    endtask

    // Small cache: hits, hand sweep with wrap, eviction at head and tail.
    task automatic test_small_cache();
        write_capacity(13'd3);
        send_addr(16'h0001);
        send_addr(16'h0002);
        send_addr(16'h0003);
        send_addr(16'h0001);
        send_addr(16'h0002);
        send_addr(16'h0003);
        send_addr(16'h0004);
        send_addr(16'h0004);
        send_addr(16'h0005);
        send_addr(16'hAAAA);
        send_addr(16'h5555);
        write_capacity(13'd1);
        send_addr(16'h5555);
        send_addr(16'h7777);
        send_addr(16'h7777);
        send_addr(16'h8888);
    endtask

    // Capacity zero, capacity lowered under occupancy, capacity above maximum.
    task automatic test_capacity_edges();
        write_capacity(13'd0);
        send_addr(16'h1234);
        send_addr(16'h1234);
        write_capacity(13'd8);
        repeat (10) send_addr(16'($urandom_range(0, 15)));
        write_capacity(13'd2);
        repeat (6) send_addr(16'($urandom_range(0, 15)));
        write_capacity(13'h1FFF);
        repeat (6) send_addr(16'($urandom_range(0, 15)));
        write_capacity(13'd4096);
        send_addr(16'h0003);
    endtask

    // Random traffic over several capacities, mostly drawn from a reuse pool.
    task automatic test_random_traffic();
        logic [scr_pkg::ADDR_W-1:0] pool[$];
        int caps[7] = '{1, 2, 5, 16, 64, 300, 4096};
        int cap;
        int n;
        for (int round = 0; round < 14; round++) begin
            cap = caps[$urandom_range(0, 6)];
            write_capacity(scr_pkg::CNT_W'(cap));
            pool.delete();
            n = (cap > 200) ? 200 : cap + cap / 2 + 2;
            for (int i = 0; i < n; i++) pool.push_back(16'($urandom));
            for (int i = 0; i < 110; i++) begin
                if ($urandom_range(0, 9) == 0) send_addr(16'($urandom));
                else send_addr(pool[$urandom_range(0, pool.size() - 1)]);
                if (round == 6 && i == 50) drain_results();
            end
        end
    endtask

    initial begin
        int settle;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        error_count = 0;
        items_sent = 0;
        hits_seen = 0;
        evictions_seen = 0;
        idle_cycles = 0;
        burst_left = 0;
        all_sent = 1'b0;
        occupied = 0;
        now_count = '0;
        head_ptr = '0;
        tail_ptr = '0;
        hand_ptr = '0;
        hand_on = 1'b0;
        cur_capacity = scr_pkg::MAX_CAP;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_capacity();
        test_small_cache();
        test_capacity_edges();
        test_random_traffic();

        // Wait for the last results, then let the block settle to catch stray output.
        s_tvalid <= 1'b0;
        all_sent = 1'b1;
        while (pending_results.size() != 0) @(negedge i_clk);
        settle = 0;
        while (settle < 64) begin
            @(negedge i_clk);
            settle++;
        end

        $display("Covered %0d accesses: %0d hits and %0d evictions over capacities from 0",
                 items_sent, hits_seen, evictions_seen);
        $display("to above the maximum, with sender gaps and receiver stalls.");
        if (error_count == 0) begin
            $display("sieve_cache_replacement_top_tb: clean");
        end else begin
            $display("sieve_cache_replacement_top_tb: errors");
        end
        $finish;
    end

endmodule

// ===== sieve_cache_replacement_top.f =====
design/scr_pkg.sv
design/scr_ram.sv
design/sieve_cache_replacement_top.sv
bench/sieve_cache_replacement_top_tb.sv
